// ----- hw/rtl/vdm_pkg.sv -----
// Shared constants, mode codes and width helpers for the vector distance metric unit.
`default_nettype none

package vdm_pkg;

    // Default vector length limit
    localparam int DEFAULT_MAX_DIM = 1024;

    // Element and result widths
    localparam int ELEM_W     = 8;
    localparam int SCORE_W    = 33;
    localparam int Q_FRAC     = 30;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_TUSER_W = 2;
    localparam int MODE_W     = 2;

    // Largest square of one element: (-128)^2
    localparam int SQ_MAX = 16384;

    // 1.0 in Q1.30
    localparam logic [Q_FRAC:0] Q_ONE = 31'h4000_0000;

    // Metric mode codes
    localparam logic [MODE_W-1:0] MODE_DOT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_L2  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COS = 2'd2;

    // Width of a squared norm sum for a given vector length limit
    function automatic int norm_w(input int max_dim);
        return $clog2(max_dim * SQ_MAX + 1);
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/vector_distance_metric_unit.sv -----
// Top level of the vector distance metric unit: front end, job queue and back end.
//
//  channel   direction  signals                               word contents (low bit up)
//  s         in         i_s_tvalid/o_s_tready/i_s_tdata/tlast elem_a[7:0], elem_b[15:8]; tlast
//  m         out        o_m_tvalid/i_m_tready/o_m_tdata/tuser score[32:0]; tuser length, zero
//  cfg       in         i_cfg_wen/i_cfg_wdata                 metric_mode[1:0]
//
//  Input words are taken one per cycle while the two-entry job queue has room.
//  Back end per vector: inner product and L2 go straight to the output stage; cosine
//  runs a multiply, the bit-serial square root, the bit-serial divider and a final step.
//  Synchronous active-low reset clears sums, queue, sequencer and metric mode.
//  A stalled output holds its word; the front keeps accepting until the queue fills.
`default_nettype none

module vector_distance_metric_unit #(
    parameter int MAX_DIM = vdm_pkg::DEFAULT_MAX_DIM
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_wen,
    input  wire logic [vdm_pkg::MODE_W-1:0]       i_cfg_wdata,  // metric_mode
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    input  wire logic [vdm_pkg::IN_TDATA_W-1:0]   i_s_tdata,    // elem_a, elem_b
    input  wire logic                             i_s_tlast,    // last_element
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    output logic [vdm_pkg::OUT_TDATA_W-1:0]       o_m_tdata,    // score, zero pad
    output logic [vdm_pkg::OUT_TUSER_W-1:0]       o_m_tuser     // length_exceeded, zero_norm
);
    import vdm_pkg::*;

    localparam int NORM_W = norm_w(MAX_DIM);
    localparam int DOT_W  = NORM_W + 1;
    localparam int JOB_W  = DOT_W + 2 * NORM_W + 1;

    logic             push, full, q_valid, pop;
    logic [JOB_W-1:0] job_in, job_out;

    // Accumulating front end
    vdm_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_job_push (push),
        .o_job      (job_in),
        .i_job_full (full)
    );

    // Job queue
    vdm_queue #(
        .W (JOB_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_din   (job_in),
        .o_full  (full),
        .o_valid (q_valid),
        .o_dout  (job_out),
        .i_pop   (pop)
    );

    // Score back end
    vdm_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_job_valid (q_valid),
        .i_job       (job_out),
        .o_job_pop   (pop),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/vdm_front.sv -----
// Front end: accepts element pairs, keeps the running sums, hands finished vectors to the queue.
`default_nettype none

module vdm_front #(
    parameter int MAX_DIM = vdm_pkg::DEFAULT_MAX_DIM,
    localparam int NORM_W = vdm_pkg::norm_w(MAX_DIM),
    localparam int DOT_W  = NORM_W + 1,
    localparam int JOB_W  = DOT_W + 2 * NORM_W + 1
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    input  wire logic [vdm_pkg::IN_TDATA_W-1:0]   i_s_tdata,  // elem_a, elem_b
    input  wire logic                             i_s_tlast,  // last_element
    output logic                                  o_job_push,
    output logic [JOB_W-1:0]                      o_job,      // dot, norm a, norm b, overflow
    input  wire logic                             i_job_full
);
    import vdm_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIM + 1);

    logic signed [DOT_W-1:0]  r_dot, n_dot;
    logic        [NORM_W-1:0] r_na, n_na;
    logic        [NORM_W-1:0] r_nb, n_nb;
    logic        [CNT_W-1:0]  r_cnt, n_cnt;
    logic                     r_ovf, n_ovf;

    logic signed [ELEM_W-1:0]   elem_a, elem_b;
    logic signed [2*ELEM_W-1:0] prod_ab, sq_a, sq_b;
    logic                       accept, room;

    assign o_s_tready = !i_job_full;
    assign accept     = i_s_tvalid && o_s_tready;

    // Element products
    assign elem_a  = signed'(i_s_tdata[ELEM_W-1:0]);
    assign elem_b  = signed'(i_s_tdata[2*ELEM_W-1:ELEM_W]);
    assign prod_ab = elem_a * elem_b;
    assign sq_a    = elem_a * elem_a;
    assign sq_b    = elem_b * elem_b;
    assign room    = r_cnt < CNT_W'(MAX_DIM);

    // Next sums; pairs past the limit only raise the overflow flag
    always_comb begin
        n_dot = r_dot;
        n_na  = r_na;
        n_nb  = r_nb;
        n_cnt = r_cnt;
        n_ovf = r_ovf;
        if (room) begin
            n_dot = r_dot + DOT_W'(prod_ab);
            n_na  = r_na + NORM_W'(unsigned'(sq_a));
            n_nb  = r_nb + NORM_W'(unsigned'(sq_b));
            n_cnt = r_cnt + CNT_W'(1);
        end else begin
            n_ovf = 1'b1;
        end
    end

    // Finished vector goes to the queue
    assign o_job_push = accept && i_s_tlast;
    assign o_job      = {n_ovf, n_nb, n_na, n_dot};

    // Running sums, cleared after each vector
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot <= '0;
            r_na  <= '0;
            r_nb  <= '0;
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else if (accept) begin
            if (i_s_tlast) begin
                r_dot <= '0;
                r_na  <= '0;
                r_nb  <= '0;
                r_cnt <= '0;
                r_ovf <= 1'b0;
            end else begin
                r_dot <= n_dot;
                r_na  <= n_na;
                r_nb  <= n_nb;
                r_cnt <= n_cnt;
                r_ovf <= n_ovf;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/vdm_queue.sv -----
// Two-entry queue of finished vector sums between front and back end.
`default_nettype none

module vdm_queue #(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_din,
    output logic              o_full,
    output logic              o_valid,
    output logic [W-1:0]      o_dout,
    input  wire logic         i_pop
);

    logic [W-1:0] r_head, r_tail;
    logic [1:0]   r_count;
    logic         push_ok, pop_ok;

    assign o_full  = r_count == 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_dout  = r_head;
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    // Head always holds the oldest entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else if (push_ok && pop_ok) begin
            if (r_count == 2'd1) begin
                r_head <= i_din;
            end else begin
                r_head <= r_tail;
                r_tail <= i_din;
            end
        end else if (pop_ok) begin
            r_head  <= r_tail;
            r_count <= r_count - 2'd1;
        end else if (push_ok) begin
            if (r_count == 2'd0) begin
                r_head <= i_din;
            end else begin
                r_tail <= i_din;
            end
            r_count <= r_count + 2'd1;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/vdm_back.sv -----
// Back end: metric register, score sequencer with square root and divider, output register.
`default_nettype none

module vdm_back #(
    parameter int MAX_DIM = vdm_pkg::DEFAULT_MAX_DIM,
    localparam int NORM_W = vdm_pkg::norm_w(MAX_DIM),
    localparam int DOT_W  = NORM_W + 1,
    localparam int JOB_W  = DOT_W + 2 * NORM_W + 1
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_wen,
    input  wire logic [vdm_pkg::MODE_W-1:0]        i_cfg_wdata,
    input  wire logic                              i_job_valid,
    input  wire logic [JOB_W-1:0]                  i_job,
    output logic                                   o_job_pop,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    output logic [vdm_pkg::OUT_TDATA_W-1:0]        o_m_tdata,  // score
    output logic [vdm_pkg::OUT_TUSER_W-1:0]        o_m_tuser   // length_exceeded, zero_norm
);
    import vdm_pkg::*;

    localparam int DVD_W  = DOT_W + Q_FRAC;
    localparam int SEQ_CW = $clog2(DVD_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SQRT,
        ST_DIV,
        ST_FIN,
        ST_DONE
    } t_state;

    t_state r_state;

    logic [MODE_W-1:0]          r_mode;
    logic signed [DOT_W-1:0]    r_dot;
    logic [NORM_W-1:0]          r_na, r_nb;
    logic                       r_ovf, r_zero;
    logic [2*NORM_W-1:0]        r_prod;
    logic [NORM_W+1:0]          r_sq_rem;
    logic [NORM_W-1:0]          r_root;
    logic [NORM_W-1:0]          r_div_rem;
    logic [DVD_W-1:0]           r_quo;
    logic [SEQ_CW-1:0]          r_cnt;
    logic signed [SCORE_W-1:0]  r_score;
    logic                       r_out_valid;
    logic signed [SCORE_W-1:0]  r_out_score;
    logic                       r_out_ovf, r_out_zero;

    // Job fields
    logic signed [DOT_W-1:0]   j_dot;
    logic [NORM_W-1:0]         j_na, j_nb;
    logic                      j_ovf;
    logic signed [SCORE_W-1:0] j_dot_x, j_l2;

    assign j_dot   = signed'(i_job[DOT_W-1:0]);
    assign j_na    = i_job[DOT_W +: NORM_W];
    assign j_nb    = i_job[DOT_W+NORM_W +: NORM_W];
    assign j_ovf   = i_job[JOB_W-1];
    assign j_dot_x = SCORE_W'(j_dot);
    assign j_l2    = signed'(SCORE_W'(j_na)) + signed'(SCORE_W'(j_nb)) - (j_dot_x <<< 1);

    // Square root step: two radicand bits in, one root bit out
    logic [NORM_W+1:0] sq_sh, sq_trial, sq_diff;
    logic              sq_ge;

    assign sq_sh    = {r_sq_rem[NORM_W-1:0], r_prod[2*NORM_W-1 -: 2]};
    assign sq_trial = {r_root, 2'b01};
    assign sq_ge    = sq_sh >= sq_trial;
    assign sq_diff  = sq_sh - sq_trial;

    // Restoring divide step: one quotient bit
    logic [NORM_W:0] dv_sh, dv_diff;
    logic            dv_ge;

    assign dv_sh   = {r_div_rem, r_quo[DVD_W-1]};
    assign dv_ge   = dv_sh >= {1'b0, r_root};
    assign dv_diff = dv_sh - {1'b0, r_root};

    // Magnitude of the dot product
    logic [DOT_W-1:0] mag;
    assign mag = r_dot[DOT_W-1] ? DOT_W'(-r_dot) : DOT_W'(r_dot);

    // Clamp quotient to 1.0 and apply the sign
    logic [Q_FRAC:0]           q_clamp;
    logic signed [SCORE_W-1:0] fin_score;

    assign q_clamp   = (r_quo > DVD_W'(Q_ONE)) ? Q_ONE : r_quo[Q_FRAC:0];
    assign fin_score = r_dot[DOT_W-1] ?
                       signed'(SCORE_W'(Q_ONE) + SCORE_W'(q_clamp)) :
                       signed'(SCORE_W'(Q_ONE) - SCORE_W'(q_clamp));

    logic out_free;
    assign out_free  = !r_out_valid || i_m_tready;
    assign o_job_pop = (r_state == ST_IDLE) && i_job_valid;

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_mode      <= MODE_DOT;
        end else begin
            if (i_cfg_wen) begin
                r_mode <= i_cfg_wdata;
            end
            // Word taken and nothing new to load this cycle
            if (r_out_valid && i_m_tready && r_state != ST_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_job_valid) begin
                        r_dot  <= j_dot;
                        r_na   <= j_na;
                        r_nb   <= j_nb;
                        r_ovf  <= j_ovf;
                        unique case (r_mode)
                            MODE_L2: begin
                                r_score <= j_l2;
                                r_zero  <= 1'b0;
                                r_state <= ST_DONE;
                            end
                            MODE_COS: begin
                                if (j_na == '0 || j_nb == '0) begin
                                    r_score <= signed'(SCORE_W'(Q_ONE));
                                    r_zero  <= 1'b1;
                                    r_state <= ST_DONE;
                                end else begin
                                    r_zero  <= 1'b0;
                                    r_state <= ST_MUL;
                                end
                            end
                            default: begin
                                r_score <= j_dot_x;
                                r_zero  <= 1'b0;
                                r_state <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_MUL: begin
                    r_prod   <= r_na * r_nb;
                    r_sq_rem <= '0;
                    r_root   <= '0;
                    r_cnt    <= '0;
                    r_state  <= ST_SQRT;
                end
                ST_SQRT: begin
                    r_prod   <= r_prod << 2;
                    r_sq_rem <= sq_ge ? sq_diff : sq_sh;
                    r_root   <= {r_root[NORM_W-2:0], sq_ge};
                    if (r_cnt == SEQ_CW'(NORM_W - 1)) begin
                        r_div_rem <= '0;
                        r_quo     <= {mag, Q_FRAC'(0)};
                        r_cnt     <= '0;
                        r_state   <= ST_DIV;
                    end else begin
                        r_cnt     <= r_cnt + SEQ_CW'(1);
                    end
                end
                ST_DIV: begin
                    r_div_rem <= dv_ge ? dv_diff[NORM_W-1:0] : dv_sh[NORM_W-1:0];
                    r_quo     <= {r_quo[DVD_W-2:0], dv_ge};
                    r_cnt     <= r_cnt + SEQ_CW'(1);
                    if (r_cnt == SEQ_CW'(DVD_W - 1)) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    r_score <= fin_score;
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_score <= r_score;
                        r_out_ovf   <= r_ovf;
                        r_out_zero  <= r_zero;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_TDATA_W'(unsigned'(r_out_score));
    assign o_m_tuser  = {r_out_zero, r_out_ovf};

`ifndef SYNTHESIS
    // A job leaves the queue only when the sequencer is free
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |-> (r_state == ST_IDLE && i_job_valid))
        else $error("job popped while sequencer busy");

    // Zero-norm words carry exactly 1.0
    a_zero_score: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_zero) |-> (r_out_score == signed'(SCORE_W'(Q_ONE))))
        else $error("zero-norm word with wrong score");

    // |dot| never exceeds floor(sqrt(na*nb)), so the quotient stays within 1.0
    a_quo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) |-> (r_quo <= DVD_W'(Q_ONE)))
        else $error("cosine quotient above one");

    // A finished score is only loaded when the output slot is free
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |=> (r_out_valid && $stable(r_out_score)))
        else $error("output word overwritten");
`endif

endmodule

`default_nettype wire
